// ===== rtl/sequential_list_table_top_defines.svh =====
// assertion macros for the sequential list table
`ifndef SEQUENTIAL_LIST_TABLE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_TABLE_TOP_DEFINES_SVH

// condition holds in the same cycle
`define SLT_ASSERT_NOW(label, cond, consequent, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (consequent)) else $error(msg);

// condition holds in the next cycle
`define SLT_ASSERT_NEXT(label, cond, consequent, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (consequent)) else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
// shared types and constants for the sequential list table
package slt_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int FUNC_W       = 3;
    localparam int LEN_W        = 11;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 3'd0,
        FN_READ   = 3'd1,
        FN_FIND   = 3'd2,
        FN_INSERT = 3'd3,
        FN_DELETE = 3'd4
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         found_position;
        logic [POS_W-1:0]         list_length;
        logic                     is_empty;
    } out_item_t;

    typedef struct packed {
        logic                     ok;
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         position;
        logic [LEN_W-1:0]         count;
        logic signed [DATA_W-1:0] data;
        logic                     hit;
        logic [POS_W-1:0]         found;
    } chain_req_t;

endpackage

// ===== rtl/slt_cell.sv =====
// one list entry cell: holds an entry and passes the request to its neighbor
module slt_cell
    import slt_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     valid_in,
    input  chain_req_t               req_in,
    input  logic signed [DATA_W-1:0] entry_right,
    output logic                     valid_out,
    output chain_req_t               req_out,
    output logic signed [DATA_W-1:0] entry_out
);

    localparam logic [LEN_W-1:0] AT_POS  = LEN_W'(INDEX + 1);
    localparam logic [LEN_W-1:0] OWN_IDX = LEN_W'(INDEX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    chain_req_t               req_reg;
    chain_req_t               req_next;
    logic                     valid_reg;
    logic                     act;
    logic                     at_pos;
    logic                     past_pos;
    logic                     match;

    always_comb begin
        act        = valid_in && req_in.ok;
        at_pos     = LEN_W'(req_in.position) == AT_POS;
        past_pos   = LEN_W'(req_in.position) <= OWN_IDX;
        match      = (OWN_IDX < req_in.count) && (entry_reg == req_in.data);
        entry_next = entry_reg;
        req_next   = req_in;
        if (act) begin
            case (req_in.func)
                FN_READ: begin
                    if (at_pos) begin
                        req_next.data = entry_reg;
                    end
                end
                FN_FIND: begin
                    if (!req_in.hit && match) begin
                        req_next.hit   = 1'b1;
                        req_next.found = POS_W'(INDEX + 1);
                    end
                end
                FN_INSERT: begin
                    if (at_pos || past_pos) begin
                        entry_next    = req_in.data;
                        req_next.data = entry_reg;
                    end
                end
                FN_DELETE: begin
                    if (at_pos || past_pos) begin
                        entry_next = entry_right;
                    end
                    if (at_pos) begin
                        req_next.data = entry_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        entry_reg <= entry_next;
    end

    assign valid_out = valid_reg;
    assign req_out   = req_reg;
    assign entry_out = entry_reg;

endmodule

// ===== rtl/sequential_list_table_top.sv =====
// Ordered list of up to CAPACITY signed 32-bit words, addressed by 1-based
// position, with clear, read, find, insert and delete requests. Each entry
// lives in its own cell of a chain; a request enters the first cell when it
// is accepted and moves one cell per cycle, shifting, reading or matching as
// it passes. One request is in flight at a time, so the block takes no new
// request until the last one has left the end of the cell chain. A finished
// result may wait at the output while the next request is accepted.
`include "sequential_list_table_top_defines.svh"

module sequential_list_table_top
    import slt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic                     hold_valid_reg;
    logic                     hold_valid_next;
    out_item_t                out_reg;
    out_item_t                out_next;
    out_item_t                hold_reg;
    out_item_t                hold_next;
    out_item_t                tail_item;
    logic                     s_accept;
    logic [LEN_W-1:0]         pos_ext;
    logic [LEN_W-1:0]         cnt_ext;
    logic                     pos_ok;
    logic                     ins_ok;
    logic                     head_ok;
    chain_req_t               head_req;
    chain_req_t               tail_req;
    logic                     tail_valid;
    logic [CAPACITY:0]        chain_valid;
    chain_req_t               chain_req   [CAPACITY+1];
    logic signed [DATA_W-1:0] chain_entry [CAPACITY];
    logic signed [DATA_W-1:0] entry_right [CAPACITY];

    assign s_ready  = !busy_reg && !hold_valid_reg;
    assign s_accept = s_valid && s_ready;

    // request check and length update
    always_comb begin
        pos_ext    = LEN_W'(s_data.position);
        cnt_ext    = LEN_W'(count_reg);
        pos_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);
        ins_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext + LEN_W'(1))
                     && (count_reg < CNT_W'(CAPACITY));
        head_ok    = 1'b0;
        count_next = count_reg;
        case (s_data.func)
            FN_CLEAR: begin
                head_ok    = 1'b1;
                count_next = '0;
            end
            FN_READ: begin
                head_ok = pos_ok;
            end
            FN_FIND: begin
                head_ok = 1'b1;
            end
            FN_INSERT: begin
                head_ok = ins_ok;
                if (ins_ok) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_DELETE: begin
                head_ok = pos_ok;
                if (pos_ok) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (!s_accept) begin
            count_next = count_reg;
        end
        head_req.ok       = head_ok;
        head_req.func     = s_data.func;
        head_req.position = s_data.position;
        head_req.count    = cnt_ext;
        head_req.data     = s_data.value;
        head_req.hit      = 1'b0;
        head_req.found    = '0;
    end

    assign chain_valid[0] = s_accept;
    assign chain_req[0]   = head_req;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == CAPACITY - 1) begin : g_last
            assign entry_right[i] = chain_entry[i];
        end else begin : g_mid
            assign entry_right[i] = chain_entry[i+1];
        end

        slt_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .valid_in   (chain_valid[i]),
            .req_in     (chain_req[i]),
            .entry_right(entry_right[i]),
            .valid_out  (chain_valid[i+1]),
            .req_out    (chain_req[i+1]),
            .entry_out  (chain_entry[i])
        );
    end

    assign tail_valid = chain_valid[CAPACITY];
    assign tail_req   = chain_req[CAPACITY];

    // result formatting at the end of the chain
    always_comb begin
        tail_item.ok             = tail_req.ok;
        tail_item.read_value     = (tail_req.ok && (tail_req.func == FN_READ
                                   || tail_req.func == FN_DELETE)) ? tail_req.data : '0;
        tail_item.found_position = tail_req.hit ? tail_req.found : '0;
        tail_item.list_length    = POS_W'(count_reg);
        tail_item.is_empty       = (count_reg == '0);
    end

    // output register with one hold slot
    always_comb begin
        busy_next       = busy_reg;
        m_valid_next    = m_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        hold_next       = hold_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end else begin
                m_valid_next = 1'b0;
            end
        end
        if (tail_valid) begin
            busy_next = 1'b0;
            if (!m_valid_reg || m_ready) begin
                out_next     = tail_item;
                m_valid_next = 1'b1;
            end else begin
                hold_next       = tail_item;
                hold_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            busy_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            busy_reg       <= busy_next;
            m_valid_reg    <= m_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `SLT_ASSERT_NEXT(a_accept_sets_busy, s_valid && s_ready, busy_reg, "request accepted without busy")
    `SLT_ASSERT_NOW(a_tail_while_busy, chain_valid[CAPACITY], busy_reg, "chain result while idle")
    `SLT_ASSERT_NOW(a_single_request, 1'b1, $onehot0(chain_valid), "more than one request in chain")
    `SLT_ASSERT_NOW(a_hold_behind_out, hold_valid_reg, m_valid_reg, "hold slot full with output empty")
    `SLT_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= CNT_W'(CAPACITY), "length above capacity")

endmodule

// ===== sim/tb.sv =====
// testbench for the sequential list table: directed and random list requests checked against a queue model
`timescale 1ns / 100ps

module tb
    import slt_pkg::*;
();

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_REQUESTS = 1700;
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FUNC_W'(FN_DELETE + 1);
    localparam logic [FUNC_W-1:0] FN_LAST_UNUSED = '1;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} stim_phase_t;

    class list_scoreboard;
        logic signed [DATA_W-1:0] entries[$];
        out_item_t expected_q[$];
        int mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_request(in_item_t req);
            out_item_t exp;
            int len;
            int pos;
            exp = '0;
            len = entries.size();
            pos = int'(req.position);
            case (req.func)
                FN_CLEAR: begin
                    entries.delete();
                    exp.ok = 1'b1;
                end
                FN_READ: begin
                    if (pos >= 1 && pos <= len) begin
                        exp.ok = 1'b1;
                        exp.read_value = entries[pos-1];
                    end
                end
                FN_FIND: begin
                    exp.ok = 1'b1;
                    for (int k = 0; k < len; k++) begin
                        if (entries[k] == req.value) begin
                            exp.found_position = POS_W'(k + 1);
                            break;
                        end
                    end
                end
                FN_INSERT: begin
                    if (pos >= 1 && pos <= len + 1 && len < LIST_CAP) begin
                        entries.insert(pos - 1, req.value);
                        exp.ok = 1'b1;
                    end
                end
                FN_DELETE: begin
                    if (pos >= 1 && pos <= len) begin
                        exp.read_value = entries[pos-1];
                        entries.delete(pos - 1);
                        exp.ok = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            exp.list_length = POS_W'(entries.size());
            exp.is_empty = (entries.size() == 0);
            expected_q.push_back(exp);
        endfunction

        task check_result(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            exp = expected_q.pop_front();
            if (got.ok !== exp.ok)
                report_mismatch($sformatf("ok %b, expected %b", got.ok, exp.ok));
            if (got.read_value !== exp.read_value)
                report_mismatch($sformatf("read_value %0d, expected %0d",
                                          got.read_value, exp.read_value));
            if (got.found_position !== exp.found_position)
                report_mismatch($sformatf("found_position %0d, expected %0d",
                                          got.found_position, exp.found_position));
            if (got.list_length !== exp.list_length)
                report_mismatch($sformatf("list_length %0d, expected %0d",
                                          got.list_length, exp.list_length));
            if (got.is_empty !== exp.is_empty)
                report_mismatch($sformatf("is_empty %b, expected %b",
                                          got.is_empty, exp.is_empty));
        endtask

        task flush_leftover();
            while (expected_q.size() != 0) begin
                report_mismatch($sformatf("missing result %p", expected_q.pop_front()));
            end
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    list_scoreboard sb;
    int idle_cycles = 0;
    bit sender_steady;
    bit receiver_steady = 1'b0;
    stim_phase_t phase;

    sequential_list_table_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic in_item_t make_req(logic [FUNC_W-1:0] fn, int pos,
                                          logic signed [DATA_W-1:0] val);
        in_item_t req;
        req.func = fn;
        req.position = POS_W'(pos);
        req.value = val;
        return req;
    endfunction

    task automatic send_request(in_item_t req);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
            return $urandom_range(0, 7);
        if (sel < 30) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic int pick_position(int lim);
        int lo;
        if (lim > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(1, lim);
        lo = (lim + 1 > 33) ? 33 : lim + 1;
        return $urandom_range(0, 1) ? 0 : $urandom_range(lo, 33);
    endfunction

    function automatic in_item_t random_request();
        int len;
        int sel;
        int w_ins;
        int w_del;
        int w_read;
        logic signed [DATA_W-1:0] val;
        len = sb.entries.size();
        sel = $urandom_range(0, 99);
        case (phase)
            PH_FILL:  begin w_ins = 65; w_del = 6;  w_read = 12; end
            PH_DRAIN: begin w_ins = 10; w_del = 55; w_read = 15; end
            default:  begin w_ins = 30; w_del = 25; w_read = 20; end
        endcase
        if (sel < w_ins)
            return make_req(FN_INSERT, pick_position(len + 1), pick_value());
        sel -= w_ins;
        if (sel < w_del)
            return make_req(FN_DELETE, pick_position(len), pick_value());
        sel -= w_del;
        if (sel < w_read)
            return make_req(FN_READ, pick_position(len), pick_value());
        sel -= w_read;
        if (sel < 95 - w_ins - w_del - w_read) begin
            if (len > 0 && $urandom_range(0, 9) < 6)
                val = sb.entries[$urandom_range(0, len - 1)];
            else
                val = pick_value();
            return make_req(FN_FIND, $urandom_range(0, 33), val);
        end
        if ($urandom_range(0, 4) < 3)
            return make_req(FN_CLEAR, $urandom_range(0, 33), pick_value());
        return make_req(FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED)),
                        $urandom_range(0, 33), pick_value());
    endfunction

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            int stall;
            if ($urandom_range(0, 49) == 0)
                receiver_steady = !receiver_steady;
            stall = receiver_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int full_tries;
        int mixed_left;
        sb = new();
        sender_steady = 1'b0;
        phase = PH_FILL;
        full_tries = 0;
        mixed_left = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list, bad positions, extremes and unused codes
        send_request(make_req(FN_CLEAR, 0, 0));
        send_request(make_req(FN_READ, 1, 0));
        send_request(make_req(FN_READ, 0, 0));
        send_request(make_req(FN_DELETE, 1, 0));
        send_request(make_req(FN_FIND, 0, 0));
        send_request(make_req(FN_INSERT, 0, 11));
        send_request(make_req(FN_INSERT, 2, 12));
        send_request(make_req(FN_INSERT, 1, VAL_MAX));
        send_request(make_req(FN_INSERT, 2, VAL_MIN));
        send_request(make_req(FN_INSERT, 1, 0));
        send_request(make_req(FN_INSERT, 4, -1));
        send_request(make_req(FN_INSERT, 6, 5));
        send_request(make_req(FN_READ, 1, 0));
        send_request(make_req(FN_READ, 4, 0));
        send_request(make_req(FN_READ, 5, 0));
        send_request(make_req(FN_FIND, 0, VAL_MIN));
        send_request(make_req(FN_FIND, 0, 12345));
        send_request(make_req(FN_DELETE, 2, 0));
        send_request(make_req(FN_DELETE, 4, 0));
        send_request(make_req(FN_INSERT, 33, 7));
        send_request(make_req(FN_READ, 33, 0));
        send_request(make_req(FN_FIRST_UNUSED, 1, 1));
        send_request(make_req(FUNC_W'(FN_FIRST_UNUSED + 1), 2, 2));
        send_request(make_req(FN_LAST_UNUSED, 63, -1));
        send_request(make_req(FN_CLEAR, 0, 0));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if ($urandom_range(0, 49) == 0)
                sender_steady = !sender_steady;
            send_request(random_request());
            case (phase)
                PH_FILL: begin
                    if (sb.entries.size() == LIST_CAP && ++full_tries > 3) begin
                        full_tries = 0;
                        phase = PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    if (sb.entries.size() == 0) begin
                        phase = PH_MIXED;
                        mixed_left = $urandom_range(30, 80);
                    end
                end
                default: begin
                    if (--mixed_left <= 0)
                        phase = PH_FILL;
                end
            endcase
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (LIST_CAP + 8) @(posedge aclk);
        sb.flush_leftover();
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
